// ===== hw/rtl/crc32fc_pkg.sv =====
// Shared types, constants and the byte-wide CRC step for the CRC-32 frame checker.
`timescale 1ns / 1ps

package crc32fc_pkg;

   // Frame format
   localparam int unsigned    HEADER_BYTES = 20;
   localparam logic [31:0]    FRAME_MAGIC  = 32'h4154_4852;

   // Reflected CRC-32
   localparam logic [31:0]    CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0]    CRC_ONES     = 32'hFFFF_FFFF;

   // Saturating byte counter
   localparam int unsigned    COUNT_WIDTH  = 17;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Reset value of the version register
   localparam logic [15:0]    VERSION_RESET = 16'd1;

   // Verdict codes, first failing check wins
   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_TOO_SHORT   = 3'd1,
      STATUS_BAD_MAGIC   = 3'd2,
      STATUS_BAD_VERSION = 3'd3,
      STATUS_BAD_LENGTH  = 3'd4,
      STATUS_CRC_ERROR   = 3'd5
   } status_type;

   // One byte transaction held in the input register
   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } item_type;

   // Verdict and header fields for one frame
   typedef struct packed {
      logic [31:0] length;
      logic [31:0] id;
      logic [15:0] kind;
      logic [15:0] version;
      status_type  status;
   } verdict_type;

   // Advance the CRC register by one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/crc32_frame_checker.sv =====
// Top level of the CRC-32 frame checker: stream ports, version register, result register.
`timescale 1ns / 1ps

// Takes a frame one byte per transaction (tlast on the final byte) and returns one
// verdict transaction per frame; payload bytes are consumed, not forwarded. The first
// 20 bytes are the little-endian header (magic, version, kind, id, length, CRC); the
// rest runs through a reflected CRC-32. One byte is accepted every cycle unless a final
// byte waits for a full result slot; the byte-wide CRC step is unrolled over eight bits
// between the input register and the frame state. The verdict is registered in the
// result register as the final byte leaves. Write csr only while no frame is in flight.

module crc32_frame_checker import crc32fc_pkg::*; #(
   parameter int unsigned MAX_PAYLOAD = 65536
) (
   input  logic         clock,
   input  logic         reset,
   // Byte stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,     // [7:0] data_byte
   input  logic         req_tlast,     // last_byte
   // Verdict stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,     // [2:0] status, [18:3] frame_version,
                                       // [34:19] frame_kind, [66:35] frame_id,
                                       // [98:67] payload_length, [103:99] zero
   // Version register
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   logic [15:0] expected_version_ff;
   logic        in_valid;
   item_type    in_item;
   item_type    req_item;
   logic        out_free;
   logic        take;
   verdict_type verdict;
   logic        rsp_valid_ff, rsp_valid_in;
   verdict_type rsp_data_ff;

   // Hold the expected version
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_version_ff <= VERSION_RESET;
      end else if (csr_wr_en) begin
         expected_version_ff <= csr_wr_data;
      end
   end

   assign req_item.data = req_tdata;
   assign req_item.last = req_tlast;

   crc32fc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .take       (take),
      .held_valid (in_valid),
      .held_item  (in_item)
   );

   // Advance a byte unless it closes a frame and the result slot is full
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign take     = in_valid && (!in_item.last || out_free);

   crc32fc_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .item             (in_item),
      .expected_version (expected_version_ff),
      .verdict          (verdict)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && in_item.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_item.last) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.length, rsp_data_ff.id,
                        rsp_data_ff.kind, rsp_data_ff.version, rsp_data_ff.status};

`ifndef ASSERT_OFF
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      take && in_item.last |=> rsp_valid_ff)
      else $error("final byte processed without a verdict");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.status <= STATUS_CRC_ERROR)
      else $error("verdict code out of range");

   a_short_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == STATUS_TOO_SHORT |->
         rsp_data_ff.id == 32'd0 && rsp_data_ff.length == 32'd0 &&
         rsp_data_ff.kind == 16'd0 && rsp_data_ff.version == 16'd0)
      else $error("short frame reported header fields");

   a_stall_only_when_held: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid && in_item.last && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a blocked final byte");
`endif

endmodule

// ===== hw/rtl/crc32fc_in_reg.sv =====
// Input register for the byte stream of the CRC-32 frame checker.
`timescale 1ns / 1ps

module crc32fc_in_reg import crc32fc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     take,        // held item is consumed this cycle
   output logic     held_valid,
   output item_type held_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // Accept when empty or when the held item leaves this cycle
   assign in_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         item_in  = in_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// ===== hw/rtl/crc32fc_core.sv =====
// Frame state: header assembly, payload CRC, byte count and verdict logic.
`timescale 1ns / 1ps

module crc32fc_core import crc32fc_pkg::*; #(
   parameter int unsigned MAX_PAYLOAD = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,              // process the item below this cycle
   input  item_type    item,
   input  logic [15:0] expected_version,
   output verdict_type verdict            // valid when take and item.last
);

   localparam logic [31:0] MaxPayloadValue = 32'(MAX_PAYLOAD);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [31:0] magic_ff, magic_in;
   logic [15:0] version_ff, version_in;
   logic [15:0] kind_ff, kind_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] hcrc_ff, hcrc_in;
   logic [31:0] crc_ff, crc_in;
   logic [4:0]  hdr_pos;
   logic        in_header;
   logic [31:0] payload_count;

   assign hdr_pos   = count_ff[4:0];
   assign in_header = count_ff < COUNT_WIDTH'(HEADER_BYTES);

   // Fold the byte into the header or the CRC, advance the count
   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      kind_in    = kind_ff;
      id_in      = id_ff;
      length_in  = length_ff;
      hcrc_in    = hcrc_ff;
      crc_in     = crc_ff;
      if (in_header) begin
         case (hdr_pos) inside
            [5'd0:5'd3]:   magic_in[8*hdr_pos[1:0] +: 8]  = item.data;
            [5'd4:5'd5]:   version_in[8*hdr_pos[0] +: 8]  = item.data;
            [5'd6:5'd7]:   kind_in[8*hdr_pos[0] +: 8]     = item.data;
            [5'd8:5'd11]:  id_in[8*hdr_pos[1:0] +: 8]     = item.data;
            [5'd12:5'd15]: length_in[8*hdr_pos[1:0] +: 8] = item.data;
            [5'd16:5'd19]: hcrc_in[8*hdr_pos[1:0] +: 8]   = item.data;
            default:       hcrc_in = hcrc_ff;
         endcase
      end else begin
         crc_in = crc_byte(crc_ff, item.data);
      end
      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_WIDTH'(1);
   end

   assign payload_count = 32'(count_in - COUNT_WIDTH'(HEADER_BYTES));

   // Run the checks in priority order on the updated state
   always_comb begin
      verdict.version = version_in;
      verdict.kind    = kind_in;
      verdict.id      = id_in;
      verdict.length  = length_in;
      if (count_in < COUNT_WIDTH'(HEADER_BYTES)) begin
         verdict.status  = STATUS_TOO_SHORT;
         verdict.version = 16'd0;
         verdict.kind    = 16'd0;
         verdict.id      = 32'd0;
         verdict.length  = 32'd0;
      end else if (magic_in != FRAME_MAGIC) begin
         verdict.status = STATUS_BAD_MAGIC;
      end else if (version_in != expected_version) begin
         verdict.status = STATUS_BAD_VERSION;
      end else if (length_in > MaxPayloadValue || length_in != payload_count) begin
         verdict.status = STATUS_BAD_LENGTH;
      end else if ((crc_in ^ CRC_ONES) != hcrc_in) begin
         verdict.status = STATUS_CRC_ERROR;
      end else begin
         verdict.status = STATUS_OK;
      end
   end

   // Update frame state; drop it back to reset values after the last byte
   always_ff @(posedge clock) begin
      if (reset || (take && item.last)) begin
         count_ff   <= '0;
         magic_ff   <= '0;
         version_ff <= '0;
         kind_ff    <= '0;
         id_ff      <= '0;
         length_ff  <= '0;
         hcrc_ff    <= '0;
         crc_ff     <= CRC_ONES;
      end else if (take) begin
         count_ff   <= count_in;
         magic_ff   <= magic_in;
         version_ff <= version_in;
         kind_ff    <= kind_in;
         id_ff      <= id_in;
         length_ff  <= length_in;
         hcrc_ff    <= hcrc_in;
         crc_ff     <= crc_in;
      end
   end

endmodule
